FILE: sv/stbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sorted table binary search block.
package stbs_pkg;

	localparam int IDX_IN_W = 10;
	localparam int VAL_IN_W = 32;
	localparam int POS_W    = 10;
	localparam int CFG_W    = 11;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic query;
		logic issue_cur;
		logic issue_next;
		logic finish;
		logic fin_step;
	} stbs_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic hit;
		logic next_len_zero;
	} stbs_sts_t;

endpackage

FILE: sv/stbs_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the input word and the result word.
interface stbs_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [stbs_pkg::IDX_IN_W-1:0]         entry_index;
	logic signed [stbs_pkg::VAL_IN_W-1:0]  value;

	modport source (output valid, output kind, output entry_index, output value, input ready);
	modport sink (input valid, input kind, input entry_index, input value, output ready);
endinterface

interface stbs_result_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [stbs_pkg::POS_W-1:0]  position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

FILE: sv/stbs_controller.sv
`timescale 1ns / 1ps
// Controller state machine that sequences loads and the probe steps of a search.
module stbs_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  stbs_pkg::stbs_sts_t sts,
	output stbs_pkg::stbs_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_STEP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_busy;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q && !out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == stbs_pkg::KIND_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.query = 1'b1;
						state_d   = ST_ISSUE;
					end
				end
			end
			ST_ISSUE: begin
				if (sts.len_zero) begin
					if (!out_busy) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.issue_cur = 1'b1;
					state_d       = ST_STEP;
				end
			end
			ST_STEP: begin
				if (sts.hit || sts.next_len_zero) begin
					if (!out_busy) begin
						cmd.finish   = 1'b1;
						cmd.fin_step = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.issue_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/stbs_datapath.sv
`timescale 1ns / 1ps
// Datapath with the table memory, the search window and the result registers.
module stbs_datapath #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stbs_pkg::stbs_cmd_t                  cmd,
	output stbs_pkg::stbs_sts_t                  sts,
	input  logic                                 cfg_wr_en,
	input  logic [stbs_pkg::CFG_W-1:0]           cfg_wr_data,
	input  logic [stbs_pkg::IDX_IN_W-1:0]        in_entry_index,
	input  logic signed [stbs_pkg::VAL_IN_W-1:0] in_value,
	output logic                                 res_found,
	output logic [stbs_pkg::POS_W-1:0]           res_position
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
	localparam int PW    = (IDX_W > stbs_pkg::POS_W) ? IDX_W : stbs_pkg::POS_W;

	logic [VALUE_WIDTH-1:0]        mem [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic signed [VALUE_WIDTH-1:0] rd_q;
	logic [LEN_W-1:0]              start_q;
	logic [LEN_W-1:0]              len_q;
	logic [LEN_W-1:0]              half;
	logic [LEN_W-1:0]              next_start;
	logic [LEN_W-1:0]              next_len;
	logic [LEN_W-1:0]              lim;
	logic [LEN_W-1:0]              addr_sum;
	logic [IDX_W-1:0]              probe_q;
	logic [IDX_W-1:0]              rd_addr;
	logic [IDX_W-1:0]              wr_addr;
	logic [PW-1:0]                 wr_idx_ext;
	logic [PW-1:0]                 probe_ext;
	logic [stbs_pkg::CFG_W-1:0]    entries_q;
	logic [63:0]                   in_ext;
	logic                          lt;
	logic                          wr_ok;
	logic                          res_found_q;
	logic [stbs_pkg::POS_W-1:0]    res_pos_q;

	assign in_ext     = {{32{in_value[31]}}, in_value};
	assign wr_idx_ext = PW'(in_entry_index);
	assign wr_addr    = wr_idx_ext[IDX_W-1:0];
	assign wr_ok      = 32'(in_entry_index) < 32'(TABLE_DEPTH);
	assign probe_ext  = PW'(probe_q);

	assign lim = (32'(entries_q) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : LEN_W'(entries_q);

	assign half       = len_q >> 1;
	assign lt         = rd_q < key_q;
	assign next_start = lt ? (LEN_W'(probe_q) + LEN_W'(1)) : start_q;
	assign next_len   = lt ? (len_q - half - LEN_W'(1)) : half;
	assign addr_sum   = cmd.issue_next ? (next_start + (next_len >> 1)) : (start_q + half);
	assign rd_addr    = addr_sum[IDX_W-1:0];

	assign sts.len_zero      = (len_q == '0);
	assign sts.hit           = (rd_q == key_q);
	assign sts.next_len_zero = (next_len == '0);

	assign res_found    = res_found_q;
	assign res_position = res_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_wr_en) begin
			entries_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			mem[wr_addr] <= in_ext[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_cur || cmd.issue_next) begin
			rd_q    <= mem[rd_addr];
			probe_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			start_q <= '0;
			len_q   <= lim;
			key_q   <= in_ext[VALUE_WIDTH-1:0];
		end else if (cmd.issue_next) begin
			start_q <= next_start;
			len_q   <= next_len;
		end
		if (cmd.finish) begin
			res_found_q <= cmd.fin_step && sts.hit;
			res_pos_q   <= (cmd.fin_step && sts.hit) ? probe_ext[stbs_pkg::POS_W-1:0] : '0;
		end
	end

endmodule

FILE: sv/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Top level of the sorted table binary search block.
// A load word writes one table entry, if its index lies within the table, and gives no result. A
// query word makes at most floor(log2(N)) + 1 probes in a search over N entries; the single read
// port of the table memory, whose read data is registered, sets the pace of one probe per cycle.
// The block takes a new word once a query has handed its result to the output register, even
// while that result still waits to be taken.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [stbs_pkg::CFG_W-1:0]  cfg_wr_data,
	stbs_item_if.sink                   item,
	stbs_result_if.source               result
);

	stbs_pkg::stbs_cmd_t cmd;
	stbs_pkg::stbs_sts_t sts;

	stbs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	stbs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_entry_index (item.entry_index),
		.in_value       (item.value),
		.res_found      (result.found),
		.res_position   (result.position)
	);

endmodule

FILE: sv/stbs_checker.sv
`timescale 1ns / 1ps
// Port checker for the sorted table binary search block and its bind.
module stbs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       found,
	input logic [stbs_pkg::POS_W-1:0] position
);

	// A result that reports a miss carries position zero.
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("miss reported with nonzero position");

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
		else $error("stalled result word changed");

	// A query keeps the input side closed in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == stbs_pkg::KIND_QUERY |=> !in_ready)
		else $error("input taken during a search");

	// A load leaves the block ready and gives no result.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == stbs_pkg::KIND_LOAD && !out_valid
		|=> in_ready && !out_valid)
		else $error("load produced a result or stalled the input");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_kind   (item.kind),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.found     (result.found),
	.position  (result.position)
);
